FILE: rtl/poly_voice_allocator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the voice allocator
// Clocked on clk; checks are disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef POLY_VOICE_ALLOCATOR_ASSERT_SVH
`define POLY_VOICE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define PVA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PVA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pva_pkg.sv
// ---------------------------------------------------------------------------
// pva_pkg
// Shared widths, controller states and command/status bundles.
// ---------------------------------------------------------------------------
package pva_pkg;

	localparam int NOTE_W    = 7;
	localparam int BEND_W    = 16;
	localparam int SLOPE_W   = 25;
	localparam int MASK_W    = 32;
	localparam int IDX_W     = 5;
	localparam int CNT_W     = 6;
	localparam int FRAC_SH   = 8;                 // Q16.0 dividend -> Q16.8 quotient
	localparam int QUO_W     = BEND_W + FRAC_SH;  // dividend / quotient width
	localparam int DIV_CNT_W = 5;                 // counts QUO_W steps

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_COMMIT,
		ST_SCAN,
		ST_RESULT
	} pva_state_t;

	typedef struct packed {
		logic load;       // request accepted: capture fields, start work
		logic div_step;   // one quotient bit
		logic commit_on;  // claim a voice with the finished slope
		logic scan_step;  // test one voice for release
	} pva_cmd_t;

	typedef struct packed {
		logic div_last;
		logic scan_last;
	} pva_stat_t;

endpackage

FILE: rtl/pva_div.sv
// ---------------------------------------------------------------------------
// pva_div
// Restoring unsigned divider, one quotient bit per step.
// ---------------------------------------------------------------------------
module pva_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic                       step,
	input  logic [pva_pkg::QUO_W-1:0]  dividend,
	input  logic [pva_pkg::BEND_W-1:0] divisor,
	output logic [pva_pkg::QUO_W-1:0]  quotient,
	output logic                       last
);

	localparam int QW = pva_pkg::QUO_W;
	localparam int BW = pva_pkg::BEND_W;
	localparam int CW = pva_pkg::DIV_CNT_W;

	logic [QW-1:0] quo_q;
	logic [BW-1:0] rem_q;
	logic [BW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic [BW:0]   shifted;
	logic [BW+1:0] diff;
	logic          fits;

	assign shifted = {rem_q, quo_q[QW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits    = !diff[BW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (step) begin
			// remainder stays below the divisor, so 16 bits hold it
			rem_q <= fits ? diff[BW-1:0] : shifted[BW-1:0];
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign last     = (cnt_q == CW'(QW - 1));

endmodule

FILE: rtl/pva_ctrl.sv
// ---------------------------------------------------------------------------
// pva_ctrl
// Event sequencer: divide for note on, voice scan for note off.
// ---------------------------------------------------------------------------
module pva_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	output logic               out_valid,
	input  logic               out_stall,
	input  pva_pkg::pva_stat_t stat,
	output pva_pkg::pva_cmd_t  cmd
);

	pva_pkg::pva_state_t state_q;
	pva_pkg::pva_state_t state_d;
	logic                can_take;
	logic                take;

	// free when idle, or when the held result leaves this edge
	assign can_take = (state_q == pva_pkg::ST_IDLE) ||
	                  ((state_q == pva_pkg::ST_RESULT) && !out_stall);
	assign take     = in_valid && can_take;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pva_pkg::ST_IDLE, pva_pkg::ST_RESULT: begin
				if (take) begin
					state_d = kind ? pva_pkg::ST_DIVIDE : pva_pkg::ST_SCAN;
				end else if (state_q == pva_pkg::ST_RESULT && !out_stall) begin
					state_d = pva_pkg::ST_IDLE;
				end
			end
			pva_pkg::ST_DIVIDE: begin
				if (stat.div_last) state_d = pva_pkg::ST_COMMIT;
			end
			pva_pkg::ST_COMMIT: state_d = pva_pkg::ST_RESULT;
			pva_pkg::ST_SCAN: begin
				if (stat.scan_last) state_d = pva_pkg::ST_RESULT;
			end
			default: state_d = pva_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = take;
		cmd.div_step  = (state_q == pva_pkg::ST_DIVIDE);
		cmd.commit_on = (state_q == pva_pkg::ST_COMMIT);
		cmd.scan_step = (state_q == pva_pkg::ST_SCAN);
		in_stall      = !can_take;
		out_valid     = (state_q == pva_pkg::ST_RESULT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pva_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/pva_datapath.sv
// ---------------------------------------------------------------------------
// pva_datapath
// Voice table, slope divider, active count and result registers.
// ---------------------------------------------------------------------------
`include "poly_voice_allocator_assert.svh"

module pva_datapath #(
	parameter int VOICES = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pva_pkg::pva_cmd_t                  cmd,
	output pva_pkg::pva_stat_t                 stat,
	input  logic [pva_pkg::NOTE_W-1:0]         note,
	input  logic signed [pva_pkg::BEND_W-1:0]  bend_start,
	input  logic signed [pva_pkg::BEND_W-1:0]  bend_end,
	input  logic [pva_pkg::BEND_W-1:0]         bend_length,
	output logic [pva_pkg::IDX_W-1:0]          voice_index,
	output logic                               assigned,
	output logic                               stolen,
	output logic [pva_pkg::MASK_W-1:0]         released_mask,
	output logic [pva_pkg::CNT_W-1:0]          active_count,
	output logic signed [pva_pkg::SLOPE_W-1:0] bend_slope
);

	localparam int IW   = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int IdxW = pva_pkg::IDX_W;
	localparam int NW   = pva_pkg::NOTE_W;
	localparam int BW   = pva_pkg::BEND_W;
	localparam int SW   = pva_pkg::SLOPE_W;
	localparam int QW   = pva_pkg::QUO_W;
	localparam int CW   = pva_pkg::CNT_W;
	localparam int FS   = pva_pkg::FRAC_SH;

	// voice table
	logic [VOICES-1:0]    active_q;
	logic [NW-1:0]        vnote_q  [VOICES];
	logic signed [SW-1:0] vslope_q [VOICES];
	logic [CW-1:0]        count_q;

	// event context
	logic [NW-1:0] note_q;
	logic          neg_q;
	logic [IW-1:0] scan_q;

	// results
	logic [IdxW-1:0]           idx_q;
	logic                      assigned_q;
	logic                      stolen_q;
	logic [pva_pkg::MASK_W-1:0] mask_q;
	logic signed [SW-1:0]      slope_q;

	logic signed [BW:0] diff;
	logic [BW-1:0]      mag;
	logic [BW-1:0]      divisor;
	logic [QW-1:0]      quotient;
	logic               div_last;
	logic [SW-1:0]      q_ext;
	logic signed [SW-1:0] slope_new;
	logic [IW-1:0]      pick;
	logic               found;
	logic               hit;
	logic [IdxW-1:0]    scan_ix;

	// |end - start| as a 16-bit magnitude plus sign
	assign diff    = {bend_end[BW-1], bend_end} - {bend_start[BW-1], bend_start};
	assign mag     = diff[BW] ? BW'(-diff) : diff[BW-1:0];
	assign divisor = (bend_length == '0) ? BW'(1) : bend_length;

	pva_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.load),
		.step     (cmd.div_step),
		.dividend ({mag, {FS{1'b0}}}),
		.divisor  (divisor),
		.quotient (quotient),
		.last     (div_last)
	);

	assign q_ext     = {{(SW - QW){1'b0}}, quotient};
	assign slope_new = neg_q ? -$signed(q_ext) : $signed(q_ext);

	// lowest free voice, last voice when all are busy
	always_comb begin
		pick  = IW'(VOICES - 1);
		found = 1'b0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				pick  = IW'(i);
				found = 1'b1;
			end
		end
	end

	assign hit     = active_q[scan_q] && (vnote_q[scan_q] == note_q);
	assign scan_ix = IdxW'(scan_q);

	assign stat.div_last  = div_last;
	assign stat.scan_last = (scan_q == IW'(VOICES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			count_q  <= '0;
			scan_q   <= '0;
			for (int i = 0; i < VOICES; i++) begin
				vnote_q[i]  <= '0;
				vslope_q[i] <= '0;
			end
		end else begin
			if (cmd.load) begin
				scan_q <= '0;
			end else if (cmd.scan_step) begin
				scan_q <= scan_q + IW'(1);
				if (hit) begin
					active_q[scan_q] <= 1'b0;
					vnote_q[scan_q]  <= '0;
					vslope_q[scan_q] <= '0;
					count_q          <= count_q - CW'(1);
				end
			end
			if (cmd.commit_on) begin
				active_q[pick] <= 1'b1;
				vnote_q[pick]  <= note_q;
				vslope_q[pick] <= slope_new;
				if (found) count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			note_q     <= note;
			neg_q      <= diff[BW];
			idx_q      <= '0;
			assigned_q <= 1'b0;
			stolen_q   <= 1'b0;
			mask_q     <= '0;
			slope_q    <= '0;
		end else begin
			if (cmd.scan_step && hit) mask_q[scan_ix] <= 1'b1;
			if (cmd.commit_on) begin
				idx_q      <= IdxW'(pick);
				assigned_q <= 1'b1;
				stolen_q   <= !found;
				slope_q    <= slope_new;
			end
		end
	end

	assign voice_index   = idx_q;
	assign assigned      = assigned_q;
	assign stolen        = stolen_q;
	assign released_mask = mask_q;
	assign active_count  = count_q;
	assign bend_slope    = slope_q;

	`PVA_ASSERT_NOW(a_count_tracks, 1'b1, count_q == CW'($countones(active_q)), "active count drifted")
	`PVA_ASSERT_NEXT(a_claim_sets, cmd.commit_on, active_q[$past(pick)], "claimed voice not active")

	for (genvar g = 0; g < VOICES; g++) begin : g_chk
		`PVA_ASSERT_NOW(a_idle_clear, !active_q[g], vnote_q[g] == '0 && vslope_q[g] == '0, "free voice holds data")
	end

endmodule

FILE: rtl/poly_voice_allocator.sv
// ---------------------------------------------------------------------------
// poly_voice_allocator
// Voice allocation with stealing for a bank of VOICES voices.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request: kind (1 note on,
//   0 note off), note, and the bend start, end and length. Output channel
//   (out_valid / out_stall) returns exactly one result per request.
//   Note on: lowest free voice is claimed, or the last voice is stolen when
//   all are busy; the slope (end-start)*256/length is found by a restoring
//   divider, one quotient bit a cycle, then written in a commit state.
//   out_valid rises once the request has passed ST_DIVIDE and ST_COMMIT.
//   Note off: voices are tested one per cycle in ST_SCAN; out_valid
//   rises once the last voice has been tested.
//   One request is in flight at a time. A waiting result is held stable while
//   out_stall is high; a new request is taken in the cycle the result leaves.
//   A note on runs through the divider and a note off through the voice
//   scan, each followed by the result state.
//   Reset (arst_n low) marks every voice free, clears stored notes, slopes
//   and the active count, and drops out_valid.
// ---------------------------------------------------------------------------
module poly_voice_allocator #(
	parameter int VOICES = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               kind,
	input  logic [pva_pkg::NOTE_W-1:0]         note,
	input  logic signed [pva_pkg::BEND_W-1:0]  bend_start,
	input  logic signed [pva_pkg::BEND_W-1:0]  bend_end,
	input  logic [pva_pkg::BEND_W-1:0]         bend_length,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pva_pkg::IDX_W-1:0]          voice_index,
	output logic                               assigned,
	output logic                               stolen,
	output logic [pva_pkg::MASK_W-1:0]         released_mask,
	output logic [pva_pkg::CNT_W-1:0]          active_count,
	output logic signed [pva_pkg::SLOPE_W-1:0] bend_slope
);

	// controller -> datapath commands, datapath -> controller status
	pva_pkg::pva_cmd_t  cmd;
	pva_pkg::pva_stat_t stat;

	pva_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// voice table, divider and result registers
	pva_datapath #(
		.VOICES (VOICES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.note          (note),
		.bend_start    (bend_start),
		.bend_end      (bend_end),
		.bend_length   (bend_length),
		.voice_index   (voice_index),
		.assigned      (assigned),
		.stolen        (stolen),
		.released_mask (released_mask),
		.active_count  (active_count),
		.bend_slope    (bend_slope)
	);

endmodule

FILE: dv/tb.sv
// ---------------------------------------------------------------------------
// tb - voice allocator testbench
// Sends note on / note off requests and checks each result against a local
// model of the voice bank: lowest free voice first, last voice stolen when
// all are busy, signed Q16.8 bend slope truncated toward zero, release by note.
// Directed corner cases come first, then randomized traffic with bursty
// sends and output stalls, then one long output hold-off.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pva_pkg::*;

	localparam int   NV        = 8;
	localparam logic KIND_OFF  = 1'b0;
	localparam logic KIND_ON   = 1'b1;
	localparam int   HOLD_LEN  = 300;   // long output hold-off, in cycles
	localparam int   TAIL_WAIT = 40;    // margin for the last request to finish

	typedef struct packed {
		logic [IDX_W-1:0]   voice_index;
		logic               assigned;
		logic               stolen;
		logic [MASK_W-1:0]  released_mask;
		logic [CNT_W-1:0]   active_count;
		logic [SLOPE_W-1:0] bend_slope;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic                      kind = KIND_OFF;
	logic [NOTE_W-1:0]         note = '0;
	logic signed [BEND_W-1:0]  bend_start = '0;
	logic signed [BEND_W-1:0]  bend_end = '0;
	logic [BEND_W-1:0]         bend_length = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [IDX_W-1:0]          voice_index;
	logic                      assigned;
	logic                      stolen;
	logic [MASK_W-1:0]         released_mask;
	logic [CNT_W-1:0]          active_count;
	logic signed [SLOPE_W-1:0] bend_slope;

	// model copy of the voice bank; all zero matches the reset state
	bit               bank_active [NV];
	bit [NOTE_W-1:0]  bank_note   [NV];
	bit [SLOPE_W-1:0] bank_slope  [NV];

	outcome_t outcome_q[$];
	outcome_t head;
	int       fail_cnt = 0;

	// sender pacing
	int gap_max = 0;
	int burst_left = 0;

	// receiver pacing
	int stall_pct = 0;
	int stall_run = 0;
	bit stall_phase = 1'b0;
	int hold_left = 0;
	bit hold_request = 1'b0;   // set by a test at negedge, taken at posedge

	always #4 clk = ~clk;

	poly_voice_allocator #(.VOICES(NV)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.note(note),
		.bend_start(bend_start),
		.bend_end(bend_end),
		.bend_length(bend_length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.voice_index(voice_index),
		.assigned(assigned),
		.stolen(stolen),
		.released_mask(released_mask),
		.active_count(active_count),
		.bend_slope(bend_slope)
	);

	// (end - start) * 256 / length, truncated toward zero; length 0 acts as 1
	function automatic logic [SLOPE_W-1:0] calc_slope(logic [BEND_W-1:0] bs,
			logic [BEND_W-1:0] be, logic [BEND_W-1:0] bl);
		longint diff;
		longint mag;
		longint den;
		longint q;
		diff = longint'($signed(be)) - longint'($signed(bs));
		den = (bl == 0) ? 1 : longint'(bl);
		mag = (diff < 0) ? -diff : diff;
		q = (mag * 256) / den;
		if (diff < 0)
			q = -q;
		return SLOPE_W'(q);
	endfunction

	// Applies one request to the model bank and returns the result it gives.
	function automatic outcome_t alloc_outcome(logic k, logic [NOTE_W-1:0] n,
			logic [BEND_W-1:0] bs, logic [BEND_W-1:0] be, logic [BEND_W-1:0] bl);
		outcome_t r;
		int pick;
		int busy;
		r = '0;
		pick = -1;
		busy = 0;
		if (k == KIND_ON) begin
			for (int v = 0; v < NV; v++)
				if (!bank_active[v] && pick < 0)
					pick = v;
			if (pick < 0) begin
				pick = NV - 1;
				r.stolen = 1'b1;
			end
			r.bend_slope = calc_slope(bs, be, bl);
			bank_active[pick] = 1'b1;
			bank_note[pick] = n;
			bank_slope[pick] = r.bend_slope;
			r.voice_index = IDX_W'(pick);
			r.assigned = 1'b1;
		end else begin
			for (int v = 0; v < NV; v++) begin
				if (bank_active[v] && bank_note[v] == n) begin
					bank_active[v] = 1'b0;
					bank_note[v] = '0;
					bank_slope[v] = '0;
					r.released_mask[v] = 1'b1;
				end
			end
		end
		for (int v = 0; v < NV; v++)
			if (bank_active[v])
				busy++;
		r.active_count = CNT_W'(busy);
		return r;
	endfunction

	// Offers one request and returns at the edge where it is taken. Valid stays
	// high into the next call unless a gap between bursts is due.
	task automatic send_req(logic k, logic [NOTE_W-1:0] n, logic [BEND_W-1:0] bs,
			logic [BEND_W-1:0] be, logic [BEND_W-1:0] bl);
		int gap;
		kind <= k;
		note <= n;
		bend_start <= bs;
		bend_end <= be;
		bend_length <= bl;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		outcome_q.insert(outcome_q.size(), alloc_outcome(k, n, bs, be, bl));
		if (gap_max > 0) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 8);
				gap = $urandom_range(1, gap_max);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Random bend fields, weighted toward extremes and short or long lengths.
	task automatic rand_bend(output logic [BEND_W-1:0] bs, output logic [BEND_W-1:0] be,
			output logic [BEND_W-1:0] bl);
		logic [BEND_W-1:0] corner [4];
		int r;
		corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
		if ($urandom_range(0, 3) == 0) begin
			bs = corner[2'($urandom_range(0, 3))];
			be = corner[2'($urandom_range(0, 3))];
		end else begin
			bs = BEND_W'($urandom);
			be = BEND_W'($urandom);
		end
		r = $urandom_range(0, 19);
		if (r == 0)
			bl = '0;
		else if (r <= 4)
			bl = BEND_W'($urandom_range(1, 16));
		else if (r <= 6)
			bl = BEND_W'($urandom_range(32768, 65535));
		else
			bl = BEND_W'($urandom_range(1, 65535));
	endtask

	// Fill the bank, steal twice, release by shared note, release an unmatched
	// note, bend extremes, zero length, rounding toward zero both ways.
	task automatic test_directed_cases();
		gap_max = 0;
		stall_pct = 30;
		send_req(KIND_ON,   0, 16'h8000, 16'h7FFF, 16'd1);      // largest slope
		send_req(KIND_ON, 127, 16'h7FFF, 16'h8000, 16'd1);      // most negative
		send_req(KIND_ON,  60, 16'h0000, 16'h0000, 16'hFFFF);   // flat bend
		send_req(KIND_ON,  60, 16'd100,  16'hFF38, 16'd0);      // zero length
		send_req(KIND_ON,  61, 16'hFFFF, 16'h0000, 16'd3);      // +256/3
		send_req(KIND_ON,  62, 16'h0000, 16'hFFFF, 16'd3);      // -256/3
		send_req(KIND_ON,  63, 16'h8000, 16'h7FFF, 16'hFFFF);
		send_req(KIND_ON,  64, 16'd1234, 16'hEF1F, 16'd777);    // bank now full
		send_req(KIND_ON,  65, 16'h1000, 16'h2000, 16'd5);      // steals last voice
		send_req(KIND_ON,  66, 16'h2000, 16'h1000, 16'd9);      // steals it again
		send_req(KIND_OFF, 64, 16'h0000, 16'h0000, 16'd1);      // note was stolen away
		send_req(KIND_OFF, 60, 16'h0000, 16'h0000, 16'd1);      // two voices at once
		send_req(KIND_OFF, 99, 16'hFFFF, 16'hFFFF, 16'hFFFF);   // no match
		send_req(KIND_ON,  70, 16'h0100, 16'h0200, 16'd256);    // reuses freed voices
		send_req(KIND_ON,  71, 16'h0200, 16'h0100, 16'd256);
		send_req(KIND_OFF,  0, 16'h0000, 16'h0000, 16'd1);
		send_req(KIND_OFF, 127, 16'h0000, 16'h0000, 16'd1);
		send_req(KIND_OFF, 70, 16'h0000, 16'h0000, 16'd1);
		send_req(KIND_OFF, 71, 16'h0000, 16'h0000, 16'd1);
		send_req(KIND_OFF, 61, 16'h0000, 16'h0000, 16'd1);
		send_req(KIND_OFF, 62, 16'h0000, 16'h0000, 16'd1);
		send_req(KIND_OFF, 63, 16'h0000, 16'h0000, 16'd1);
		send_req(KIND_OFF, 66, 16'h0000, 16'h0000, 16'd1);      // bank empty again
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Phases of random traffic. Notes mostly come from a small window so that
	// note offs find their voices, the bank fills and stealing happens.
	task automatic test_random_traffic();
		int gaps [3];
		int stalls [3];
		int base;
		int span;
		logic k;
		logic [NOTE_W-1:0] n;
		logic [BEND_W-1:0] bs;
		logic [BEND_W-1:0] be;
		logic [BEND_W-1:0] bl;
		gaps = '{1, 4, 12};
		stalls = '{10, 40, 75};
		for (int seg = 0; seg < 6; seg++) begin
			if (seg == 0) begin
				gap_max = 0;       // back to back, no stalls
				stall_pct = 0;
			end else begin
				gap_max = gaps[2'($urandom_range(0, 2))];
				stall_pct = stalls[2'($urandom_range(0, 2))];
			end
			base = $urandom_range(0, 111);
			span = $urandom_range(1, 15);
			for (int i = 0; i < 275; i++) begin
				k = ($urandom_range(0, 99) < 55) ? KIND_ON : KIND_OFF;
				if ($urandom_range(0, 99) < 15)
					n = NOTE_W'($urandom_range(0, 127));
				else
					n = NOTE_W'(base + int'($urandom_range(0, span)));
				rand_bend(bs, be, bl);
				send_req(k, n, bs, be, bl);
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Output held off for a long stretch while requests keep coming, so the
	// block backs up and stalls its input.
	task automatic test_backpressure();
		logic [BEND_W-1:0] bs;
		logic [BEND_W-1:0] be;
		logic [BEND_W-1:0] bl;
		gap_max = 0;
		stall_pct = 20;
		@(negedge clk);
		hold_request = 1'b1;
		@(posedge clk);
		for (int i = 0; i < 60; i++) begin
			rand_bend(bs, be, bl);
			send_req(($urandom_range(0, 1) == 1) ? KIND_ON : KIND_OFF,
				NOTE_W'($urandom_range(20, 27)), bs, be, bl);
		end
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Receiver stall pattern: random runs of stall and no stall, with a long
	// hold-off on request.
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_LEN;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_run > 0) begin
			stall_run--;
			out_stall <= stall_phase;
		end else begin
			stall_phase = ($urandom_range(0, 99) < stall_pct);
			stall_run = stall_phase ? $urandom_range(1, 8) : $urandom_range(1, 10);
			out_stall <= stall_phase;
		end
	end

	function automatic void chk_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			fail_cnt++;
		end
	endfunction

	// Result checker: every accepted result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (outcome_q.size() == 0) begin
				$error("result with no request outstanding");
				fail_cnt++;
			end else begin
				head = outcome_q.pop_front();
				chk_field("voice_index", 32'(head.voice_index), 32'(voice_index));
				chk_field("assigned", 32'(head.assigned), 32'(assigned));
				chk_field("stolen", 32'(head.stolen), 32'(stolen));
				chk_field("released_mask", head.released_mask, released_mask);
				chk_field("active_count", 32'(head.active_count), 32'(active_count));
				chk_field("bend_slope", 32'(head.bend_slope), 32'(unsigned'(bend_slope)));
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_traffic();
		test_backpressure();
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (outcome_q.size() == 0 && fail_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// slowest correct run is under 0.8 ms
	initial begin
		#4ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pva_pkg.sv
rtl/pva_div.sv
rtl/pva_ctrl.sv
rtl/pva_datapath.sv
rtl/poly_voice_allocator.sv
dv/tb.sv
